### rtl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared codes, constants and types of the I2C master bit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbe_pkg;

  // Command codes, also the engine state (idle is zero)
  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;
  localparam logic [2:0] CMD_RECV  = 3'd5;
  localparam logic [2:0] CMD_ACK   = 3'd6;

  // Start status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Register index of the delay register
  localparam logic REG_DELAY_TICKS = 1'b0;

  localparam logic [7:0]  DELAY_RESET = 8'd15;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified request as it waits in the queue
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // Queue status seen by the engine
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### rtl/i2cbe_if.sv
// ----------------------------------------------------------------------------
// i2cbe_in_if / i2cbe_out_if
// Valid/ready channels carrying tick requests and per-tick results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] tx_byte;
  logic       ack_level;
  logic       sda_in;

  modport source (output valid, mode, tx_byte, ack_level, sda_in, input ready);
  modport sink   (input valid, mode, tx_byte, ack_level, sda_in, output ready);
endinterface

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_drive;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_data;
  logic       ack_seen;
  logic [1:0] status;

  modport source (output valid, scl_drive, sda_drive, busy_res, done_res, rx_data,
                  ack_seen, status, input ready);
  modport sink   (input valid, scl_drive, sda_drive, busy_res, done_res, rx_data,
                  ack_seen, status, output ready);
endinterface

### rtl/i2cbe_front.sv
// ----------------------------------------------------------------------------
// i2cbe_front
// Accept tick requests, classify the mode and hold them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbe_front #(
  parameter int unsigned QDepth = i2cbe_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cbe_in_if.sink          in_i,
  input  logic              pop_i,
  output i2cbe_pkg::item_t  head_o,
  output i2cbe_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  i2cbe_pkg::item_t mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push;
  i2cbe_pkg::item_t new_item;

  // Tag real commands so the engine only checks one bit
  always_comb begin
    new_item.is_cmd    = in_i.mode inside {[i2cbe_pkg::CMD_START:i2cbe_pkg::CMD_ACK]};
    new_item.mode      = in_i.mode;
    new_item.tx_byte   = in_i.tx_byte;
    new_item.ack_level = in_i.ack_level;
    new_item.sda_in    = in_i.sda_in;
  end

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(QDepth));
  assign in_i.ready   = !stat_o.full;
  assign push         = in_i.valid && in_i.ready;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

### rtl/i2cbe_engine.sv
// ----------------------------------------------------------------------------
// i2cbe_engine
// Bit sequencer: advance one tick per popped request, register the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cbe_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2cbe_pkg::item_t   head_i,
  input  i2cbe_pkg::q_stat_t stat_i,
  input  logic [7:0]         delay_ticks_i,
  output logic               pop_o,
  i2cbe_out_if.source        out_o
);

  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
  } seg_t;

  // Line change at the head of a delay segment
  function automatic seg_t seg_begin(input logic [2:0] cmd, input logic [1:0] step,
                                     input logic [7:0] shift, input logic scl,
                                     input logic sda);
    seg_t r;
    r.scl   = scl;
    r.sda   = sda;
    r.shift = shift;
    case (cmd)
      i2cbe_pkg::CMD_START: begin
        if (step == 2'd0) begin
          r.scl = 1'b1;
          r.sda = 1'b1;
        end else if (step == 2'd1) begin
          r.sda = 1'b0;
        end else begin
          r.scl = 1'b0;
        end
      end
      i2cbe_pkg::CMD_STOP: begin
        case (step)
          2'd0:    r.scl = 1'b0;
          2'd1:    r.sda = 1'b0;
          2'd2:    r.scl = 1'b1;
          default: r.sda = 1'b1;
        endcase
      end
      i2cbe_pkg::CMD_ACK: begin
        case (step)
          2'd0:    r.scl = 1'b0;
          2'd1:    r.sda = shift[7];
          2'd2:    r.scl = 1'b1;
          default: r.scl = 1'b0;
        endcase
      end
      i2cbe_pkg::CMD_WAIT: begin
        if (step == 2'd0) begin
          r.scl = 1'b0;
        end else if (step == 2'd1) begin
          r.sda = 1'b1;
        end else begin
          r.scl = 1'b1;
        end
      end
      i2cbe_pkg::CMD_SEND: begin
        if (step == 2'd0) begin
          r.scl = 1'b0;
        end else if (step == 2'd1) begin
          r.sda   = shift[7];
          r.shift = {shift[6:0], 1'b0};
        end else begin
          r.scl = 1'b1;
        end
      end
      i2cbe_pkg::CMD_RECV: begin
        if (step == 2'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else begin
          r.scl = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  logic [2:0] cmd_q, cmd_d;
  logic [1:0] step_q, step_d;
  logic [3:0] bits_q, bits_d;
  logic [7:0] dly_q, dly_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] rx_q, rx_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       ack_q, ack_d;
  logic [1:0] status_q, status_d;
  logic       done;
  logic       fin;
  logic       adv;
  logic       do_begin;
  seg_t       seg;
  logic [7:0] dly_load;
  logic       out_valid_q;

  assign dly_load = (delay_ticks_i == 8'd0) ? 8'd1 : delay_ticks_i;
  assign pop_o    = !stat_i.empty && (!out_valid_q || out_o.ready);

  always_comb begin
    cmd_d    = cmd_q;
    step_d   = step_q;
    bits_d   = bits_q;
    dly_d    = dly_q;
    shift_d  = shift_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    status_d = status_q;
    done     = 1'b0;
    fin      = 1'b0;
    adv      = 1'b0;
    do_begin = 1'b0;
    seg      = '0;

    if (cmd_q == i2cbe_pkg::CMD_IDLE) begin
      if (head_i.is_cmd) begin
        cmd_d  = head_i.mode;
        step_d = 2'd0;
        bits_d = 4'd0;
        if (head_i.mode == i2cbe_pkg::CMD_SEND) begin
          shift_d = head_i.tx_byte;
        end else if (head_i.mode == i2cbe_pkg::CMD_ACK) begin
          shift_d = {head_i.ack_level, 7'd0};
        end else begin
          shift_d = 8'd0;
        end
        do_begin = 1'b1;
      end
    end else if (dly_q <= 8'd1) begin
      dly_d = 8'd0;
      case (cmd_q)
        i2cbe_pkg::CMD_START: begin
          if (step_q == 2'd0 && !head_i.sda_in) begin
            status_d = i2cbe_pkg::ST_BUSY;
            fin      = 1'b1;
          end else if (step_q == 2'd1 && head_i.sda_in) begin
            status_d = i2cbe_pkg::ST_ERROR;
            fin      = 1'b1;
          end else if (step_q >= 2'd2) begin
            status_d = i2cbe_pkg::ST_OK;
            fin      = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        i2cbe_pkg::CMD_STOP, i2cbe_pkg::CMD_ACK: begin
          if (step_q == 2'd3) begin
            fin = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        i2cbe_pkg::CMD_WAIT: begin
          if (step_q >= 2'd2) begin
            ack_d = !head_i.sda_in;
            scl_d = 1'b0;
            fin   = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        i2cbe_pkg::CMD_SEND: begin
          if (step_q >= 2'd2) begin
            bits_d = bits_q + 4'd1;
            if (bits_d == BYTE_BITS) begin
              scl_d = 1'b0;
              fin   = 1'b1;
            end else begin
              step_d   = 2'd0;
              do_begin = 1'b1;
            end
          end else begin
            adv = 1'b1;
          end
        end
        i2cbe_pkg::CMD_RECV: begin
          if (step_q >= 2'd1) begin
            shift_d = {shift_q[6:0], head_i.sda_in};
            bits_d  = bits_q + 4'd1;
            if (bits_d == BYTE_BITS) begin
              rx_d  = shift_d;
              scl_d = 1'b0;
              fin   = 1'b1;
            end else begin
              step_d   = 2'd0;
              do_begin = 1'b1;
            end
          end else begin
            adv = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
      if (adv) begin
        step_d   = step_q + 2'd1;
        do_begin = 1'b1;
      end
      if (fin) begin
        cmd_d  = i2cbe_pkg::CMD_IDLE;
        step_d = 2'd0;
        bits_d = 4'd0;
        dly_d  = 8'd0;
        done   = 1'b1;
      end
    end else begin
      dly_d = dly_q - 8'd1;
    end

    if (do_begin) begin
      seg     = seg_begin(cmd_d, step_d, shift_d, scl_d, sda_d);
      scl_d   = seg.scl;
      sda_d   = seg.sda;
      shift_d = seg.shift;
      dly_d   = dly_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= i2cbe_pkg::CMD_IDLE;
      step_q   <= '0;
      bits_q   <= '0;
      dly_q    <= '0;
      shift_q  <= '0;
      rx_q     <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_q    <= 1'b0;
      status_q <= i2cbe_pkg::ST_OK;
    end else if (pop_o) begin
      cmd_q    <= cmd_d;
      step_q   <= step_d;
      bits_q   <= bits_d;
      dly_q    <= dly_d;
      shift_q  <= shift_d;
      rx_q     <= rx_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_q    <= ack_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_o.scl_drive <= scl_d;
      out_o.sda_drive <= sda_d;
      out_o.busy_res  <= (cmd_d != i2cbe_pkg::CMD_IDLE);
      out_o.done_res  <= done;
      out_o.rx_data   <= rx_d;
      out_o.ack_seen  <= ack_d;
      out_o.status    <= status_d;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

### rtl/i2c_master_bit_engine_core.sv
// A request is written into the front queue; when the sequencer pops it, its result is registered.
// Throughput: one request per cycle while the sink takes results; the sequencer then retires one tick each cycle.
// A stalled result register holds the sequencer; the queue (two entries by default) then fills.
// Reset: sequencer idle, SCL and SDA released high, flags and data cleared,
// delay_ticks back to 15, queue empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// Bit-banged I2C master: front queue, tick sequencer and APB delay register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_engine_core #(
  parameter int unsigned QDepth = i2cbe_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbe_in_if.sink    in_i,
  i2cbe_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cbe_pkg::item_t   head;
  i2cbe_pkg::q_stat_t q_stat;
  logic               eng_pop;
  logic [7:0]         delay_q;
  logic               reg_sel;

  // Word index of the register; only the delay register exists
  assign reg_sel = (paddr[2] == i2cbe_pkg::REG_DELAY_TICKS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {24'd0, delay_q} : 32'd0;

  // Take the write on the access phase; the block is idle by contract
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= i2cbe_pkg::DELAY_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      delay_q <= pwdata[7:0];
    end
  end

  // Front: accept and classify requests, buffer them ahead of the sequencer
  i2cbe_front #(
    .QDepth (QDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (eng_pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // Back: advance the bus sequencer one tick per popped request
  i2cbe_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .stat_i        (q_stat),
    .delay_ticks_i (delay_q),
    .pop_o         (eng_pop),
    .out_o         (out_o)
  );

  // The sequencer never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_pop |-> !q_stat.empty)
    else $error("sequencer popped an empty queue");

  // A finishing tick reports not busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.busy_res && out_o.done_res))
    else $error("done and busy reported together");

  // Status holds one of the defined start outcomes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status == i2cbe_pkg::ST_OK ||
                     out_o.status == i2cbe_pkg::ST_BUSY ||
                     out_o.status == i2cbe_pkg::ST_ERROR))
    else $error("undefined status code");

  // A full queue means the sequencer is held back by the result register
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full && !eng_pop |-> out_o.valid && !out_o.ready)
    else $error("queue full while sequencer free");

endmodule
